>>> rtl/calc_pkg.sv
package calc_pkg;

	localparam int NUM_SLOTS = 2;
	localparam int LOADS_W   = $clog2(NUM_SLOTS + 1);

	localparam int CODE_W  = 24;
	localparam int BYTE_W  = 8;
	localparam int COUNT_W = 3;

	localparam logic [CODE_W-1:0]  ERASED_CODE = 24'hFF_FFFF;
	localparam logic [COUNT_W-1:0] CHECK_POS   = 3'd5;
	localparam logic [COUNT_W-1:0] SUM_POS     = 3'd4;

	localparam logic [2:0] ST_NONE    = 3'd0;
	localparam logic [2:0] ST_STORED  = 3'd1;
	localparam logic [2:0] ST_BAD_OPN = 3'd2;
	localparam logic [2:0] ST_REFUSED = 3'd3;
	localparam logic [2:0] ST_OPENED  = 3'd4;
	localparam logic [2:0] ST_LOCKED  = 3'd5;

	typedef logic [CODE_W-1:0] code_t;
	typedef logic [BYTE_W-1:0] byte_t;

endpackage

>>> rtl/card_access_lock_controller.sv
// Card access lock controller.
// Input channel (in_valid/in_ready): mode selects a serial byte (rx_byte, mode 0)
// or a decoded card code (card_code, mode 1). Every input transfer yields exactly
// one result transfer on the output channel (out_valid/out_ready) carrying
// echo_valid, echo_byte, status, load_done and door_open_out.
// Serial bytes are echoed and gathered into 6-byte frames; the sixth byte is the
// checksum, and a good frame written while the door is open loads the slot that
// byte 0 names with bytes 1..3.
// The result appears in the cycle after the input transfer, from the result
// register. Throughput: one item per cycle while the receiver does not stall; the
// frame state and the slot compares are updated in the same cycle the item is taken.
// in_ready is high whenever the result register is empty or being drained, so
// a stalled receiver holds the result and blocks new input only while it stalls.
// Reset: all slots erased (all ones), door open, load mode, no frame gathered.
// In load mode cards are ignored; after NUM_SLOTS stored frames the door locks and
// load_done is reported.
module card_access_lock_controller (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         mode,
	input  logic [7:0]                   rx_byte,
	input  logic [23:0]                  card_code,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         echo_valid,
	output logic [7:0]                   echo_byte,
	output logic [2:0]                   status,
	output logic                         load_done,
	output logic                         door_open_out
);

	calc_pkg::byte_t                       frame_q [4];
	calc_pkg::byte_t                       sum_q;
	logic [calc_pkg::COUNT_W-1:0]          byte_count_q;
	calc_pkg::code_t                       slot_q [calc_pkg::NUM_SLOTS];
	logic                                  door_open_q;
	logic                                  load_mode_q;
	logic [calc_pkg::LOADS_W-1:0]          loads_q;

	logic                                  out_valid_q;
	logic                                  echo_valid_q;
	calc_pkg::byte_t                       echo_byte_q;
	logic [2:0]                            status_q;
	logic                                  load_done_q;
	logic                                  door_out_q;

	logic                                  accept;
	logic                                  is_check;
	logic                                  slot_ok;
	logic                                  frame_ok;
	logic                                  finish_load;
	logic                                  hit;
	logic                                  door_nxt;
	logic [2:0]                            status_nxt;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	assign is_check = (byte_count_q == calc_pkg::CHECK_POS);
	assign slot_ok  = (frame_q[0] != '0) &&
		(frame_q[0] <= calc_pkg::BYTE_W'(calc_pkg::NUM_SLOTS));
	assign frame_ok = (sum_q == rx_byte) && door_open_q && slot_ok;
	assign finish_load = frame_ok && load_mode_q &&
		(loads_q == calc_pkg::LOADS_W'(calc_pkg::NUM_SLOTS - 1));

	always_comb begin
		hit = 1'b0;
		for (int i = 0; i < calc_pkg::NUM_SLOTS; i++) begin
			if (slot_q[i] == card_code)
				hit = 1'b1;
		end
	end

	always_comb begin
		door_nxt   = door_open_q;
		status_nxt = calc_pkg::ST_NONE;
		if (!mode) begin
			if (is_check) begin
				if (frame_ok) begin
					status_nxt = calc_pkg::ST_STORED;
					if (finish_load)
						door_nxt = 1'b0;
				end else begin
					status_nxt = door_open_q ? calc_pkg::ST_BAD_OPN : calc_pkg::ST_REFUSED;
				end
			end
		end else if (!load_mode_q && hit) begin
			door_nxt   = !door_open_q;
			status_nxt = door_open_q ? calc_pkg::ST_LOCKED : calc_pkg::ST_OPENED;
		end
	end

	// frame gathering; byte 4 only enters the running sum
	always_ff @(posedge clk) begin
		if (accept && !mode && !is_check) begin
			if (byte_count_q != calc_pkg::SUM_POS)
				frame_q[byte_count_q[1:0]] <= rx_byte;
			sum_q <= (byte_count_q == '0) ? rx_byte : sum_q + rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			door_open_q  <= 1'b1;
			load_mode_q  <= 1'b1;
			loads_q      <= '0;
			for (int i = 0; i < calc_pkg::NUM_SLOTS; i++)
				slot_q[i] <= calc_pkg::ERASED_CODE;
		end else if (accept) begin
			door_open_q <= door_nxt;
			if (!mode) begin
				byte_count_q <= is_check ? '0 : byte_count_q + 1'b1;
				if (is_check && frame_ok) begin
					for (int i = 0; i < calc_pkg::NUM_SLOTS; i++) begin
						if (frame_q[0] == calc_pkg::BYTE_W'(i + 1))
							slot_q[i] <= {frame_q[1], frame_q[2], frame_q[3]};
					end
					if (load_mode_q) begin
						loads_q <= loads_q + 1'b1;
						if (finish_load)
							load_mode_q <= 1'b0;
					end
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			echo_valid_q <= !mode;
			echo_byte_q  <= mode ? '0 : rx_byte;
			status_q     <= status_nxt;
			load_done_q  <= !mode && is_check && finish_load;
			door_out_q   <= door_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign echo_valid    = echo_valid_q;
	assign echo_byte     = echo_byte_q;
	assign status        = status_q;
	assign load_done     = load_done_q;
	assign door_open_out = door_out_q;

`ifndef NO_ASSERTIONS
	a_load_done_locks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && load_done |-> status == calc_pkg::ST_STORED && !door_open_out)
		else $error("load_done without store and lock");

	a_load_mode_open: assert property (@(posedge clk) disable iff (!arst_n)
		load_mode_q |-> door_open_q)
		else $error("door locked while in load mode");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_count_q <= calc_pkg::CHECK_POS)
		else $error("frame byte count out of range");

	a_card_no_echo: assert property (@(posedge clk) disable iff (!arst_n)
		accept && mode |=> out_valid && !echo_valid && echo_byte == '0 && !load_done)
		else $error("card result carries echo or load_done");
`endif

endmodule
